@@ hdl/sidc_pkg.sv @@
package sidc_pkg;

    localparam int LIST_DEPTH  = 1024;
    localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int CMD_W       = 2;
    localparam int ID_W        = 32;
    localparam int SCORE_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [CMD_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEST   = 2'd2,
        OP_SEEK   = 2'd3
    } sidc_op_t;

    typedef struct packed {
        sidc_op_t             op;
        logic [ID_W-1:0]      id;
        logic [SCORE_W-1:0]   score;
    } sidc_cmd_t;

endpackage

@@ hdl/sidc_front.sv @@
module sidc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sidc_pkg::CMD_W-1:0]  cmd,
    input  logic [sidc_pkg::ID_W-1:0]   doc_id,
    input  logic [sidc_pkg::SCORE_W-1:0] score_in,
    output logic                        q_valid,
    input  logic                        q_pop,
    output sidc_pkg::sidc_cmd_t         q_head
);
    import sidc_pkg::*;

    sidc_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    sidc_cmd_t         word_in;
    logic              push;

    // classify the incoming word into an operation
    always_comb
    begin
        word_in.op    = sidc_op_t'(cmd);
        word_in.id    = doc_id;
        word_in.score = score_in;
    end

    assign in_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign q_head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= word_in;
        end
    end

endmodule

@@ hdl/sidc_back.sv @@
module sidc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  sidc_pkg::sidc_cmd_t          q_head,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [sidc_pkg::ID_W-1:0]    found_id,
    output logic [sidc_pkg::SCORE_W-1:0] score_out,
    output logic                         list_full
);
    import sidc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN_RD,
        ST_SCAN_RD,
        ST_SCAN_CHK
    } state_t;

    state_t               state_reg, state_next;
    sidc_op_t             op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     cursor_reg, cursor_next;
    logic                 wv_reg, wv_next;
    logic                 end_reg, end_next;
    logic [ID_W-1:0]      wl_reg, wl_next;
    logic [ID_W-1:0]      wh_reg, wh_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;
    logic [ID_W-1:0]      found_reg, found_next;
    logic [SCORE_W-1:0]   score_reg, score_next;
    logic                 full_reg, full_next;

    // id in the upper half, score in the lower half
    logic [ID_W+SCORE_W-1:0] list_mem [LIST_DEPTH];
    logic [ID_W+SCORE_W-1:0] rdata_reg;
    logic                    rd_en, wr_en;
    logic [IDX_W-1:0]        rd_addr;

    logic                 out_free;
    logic                 in_win;
    logic [ID_W-1:0]      rid;
    logic [SCORE_W-1:0]   rscore;

    assign out_free = !out_valid_reg || out_ready;
    assign in_win   = wv_reg && (q_head.id >= wl_reg);
    assign rid      = rdata_reg[ID_W+SCORE_W-1:SCORE_W];
    assign rscore   = rdata_reg[SCORE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cursor_next    = cursor_reg;
        wv_next        = wv_reg;
        end_next       = end_reg;
        wl_next        = wl_reg;
        wh_next        = wh_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        score_next     = score_reg;
        full_next      = full_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cursor_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop   = 1'b1;
                    op_next = q_head.op;
                    id_next = q_head.id;
                    unique case (q_head.op)
                        OP_CLEAR, OP_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            hit_next       = 1'b0;
                            found_next     = '0;
                            score_next     = '0;
                            full_next      = 1'b0;
                            if (q_head.op == OP_APPEND && count_reg >= CNT_W'(LIST_DEPTH))
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                if (q_head.op == OP_APPEND)
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    count_next = '0;
                                end
                                // any change to the list invalidates the window
                                wv_next     = 1'b0;
                                end_next    = 1'b0;
                                wl_next     = '0;
                                wh_next     = '0;
                                cursor_next = '0;
                            end
                        end
                        OP_TEST:
                        begin
                            if (in_win && !end_reg && q_head.id == wh_reg)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_WIN_RD;
                            end
                            else if (in_win && (end_reg || q_head.id < wh_reg))
                            begin
                                out_valid_next = 1'b1;
                                hit_next       = 1'b0;
                                found_next     = '0;
                                score_next     = '0;
                                full_next      = 1'b0;
                            end
                            else
                            begin
                                idx_next   = in_win ? CNT_W'(cursor_reg) + 1'b1 : '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        OP_SEEK:
                        begin
                            if (in_win && end_reg)
                            begin
                                out_valid_next = 1'b1;
                                hit_next       = 1'b0;
                                found_next     = '0;
                                score_next     = '0;
                                full_next      = 1'b0;
                            end
                            else if (in_win && q_head.id <= wh_reg)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_WIN_RD;
                            end
                            else
                            begin
                                wl_next    = q_head.id;
                                wv_next    = 1'b1;
                                idx_next   = in_win ? CNT_W'(cursor_reg) + 1'b1 : '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                    endcase
                end
            end

            ST_WIN_RD:
            begin
                // answer straight from the window, score read at the cursor
                out_valid_next = 1'b1;
                hit_next       = 1'b1;
                found_next     = wh_reg;
                score_next     = rscore;
                full_next      = 1'b0;
                state_next     = ST_IDLE;
            end

            ST_SCAN_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[IDX_W-1:0];
                    state_next = ST_SCAN_CHK;
                end
                else
                begin
                    if (op_reg == OP_SEEK)
                    begin
                        end_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    found_next     = '0;
                    score_next     = '0;
                    full_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN_CHK:
            begin
                if ((op_reg == OP_TEST && rid == id_reg) ||
                    (op_reg != OP_TEST && rid >= id_reg))
                begin
                    if (op_reg == OP_TEST)
                    begin
                        wl_next = id_reg;
                        wv_next = 1'b1;
                    end
                    wh_next        = rid;
                    cursor_next    = idx_reg[IDX_W-1:0];
                    end_next       = 1'b0;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b1;
                    found_next     = rid;
                    score_next     = rscore;
                    full_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (op_reg == OP_TEST && rid > id_reg)
                begin
                    // passed the id without a match
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    found_next     = '0;
                    score_next     = '0;
                    full_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_CLEAR;
            id_reg        <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            cursor_reg    <= '0;
            wv_reg        <= 1'b0;
            end_reg       <= 1'b0;
            wl_reg        <= '0;
            wh_reg        <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
            score_reg     <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cursor_reg    <= cursor_next;
            wv_reg        <= wv_next;
            end_reg       <= end_next;
            wl_reg        <= wl_next;
            wh_reg        <= wh_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            score_reg     <= score_next;
            full_reg      <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_mem[count_reg[IDX_W-1:0]] <= {q_head.id, q_head.score};
        end
        if (rd_en)
        begin
            rdata_reg <= list_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign found_id  = found_reg;
    assign score_out = score_reg;
    assign list_full = full_reg;

endmodule

@@ hdl/sorted_id_list_cursor.sv @@
// Path from input accept to result valid: clear, append and a query that the window rejects
// outright are answered from the idle state; a query answered from the window passes through
// the window read state; a scan alternates read and check states until a match or the end.
// Throughput: one clear or append per cycle while the result register is free; a scan
// reads and then compares each entry, through the single read port of the list memory.
// Reset: list empty, window invalid, queue and result register empty; no clear pass.
module sorted_id_list_cursor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sidc_pkg::CMD_W-1:0]   cmd,
    input  logic [sidc_pkg::ID_W-1:0]    doc_id,
    input  logic [sidc_pkg::SCORE_W-1:0] score_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic [sidc_pkg::ID_W-1:0]    found_id,
    output logic [sidc_pkg::SCORE_W-1:0] score_out,
    output logic                         list_full
);
    import sidc_pkg::*;

    logic      q_valid;
    logic      q_pop;
    sidc_cmd_t q_head;

    sidc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .doc_id   (doc_id),
        .score_in (score_in),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    sidc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .found_id  (found_id),
        .score_out (score_out),
        .list_full (list_full)
    );

endmodule

@@ hdl/sidc_checker.sv @@
module sidc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         hit,
    input  logic [sidc_pkg::ID_W-1:0]    found_id,
    input  logic [sidc_pkg::SCORE_W-1:0] score_out,
    input  logic                         list_full
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_id) && $stable(hit))
        else $error("result word changed while stalled");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && list_full))
        else $error("refused append reported as hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> found_id == '0 && score_out == '0)
        else $error("miss carries nonzero id or score");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_full |-> found_id == '0)
        else $error("refused append carries an id");

endmodule

bind sorted_id_list_cursor sidc_checker u_sidc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .found_id  (found_id),
    .score_out (score_out),
    .list_full (list_full)
);

@@ dv/tb_sorted_id_list_cursor.sv @@
`timescale 1ns / 1ps

module tb_sorted_id_list_cursor;

    import sidc_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_WORDS = 400;

    typedef struct packed {
        logic               hit;
        logic [ID_W-1:0]    found;
        logic [SCORE_W-1:0] score;
        logic               full;
    } lookup_t;

    typedef struct packed {
        sidc_op_t           op;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] sc;
        logic               typed;
        lookup_t            res;
    } dir_row_t;

    localparam lookup_t NONE = '{1'b0, 32'h0, 32'h0, 1'b0};
    localparam lookup_t ANY  = '{1'b0, 32'h0, 32'h0, 1'b0};

    // typed rows carry their result, the rest go through the predictor
    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{OP_SEEK,   32'h0000_0000, 32'h0000_0000, 1'b1, NONE},
        '{OP_TEST,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NONE},
        '{OP_APPEND, 32'h0000_0000, 32'h0000_0000, 1'b1, NONE},
        '{OP_APPEND, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1, NONE},
        '{OP_APPEND, 32'h0000_000A, 32'h0001_0000, 1'b1, NONE},
        '{OP_APPEND, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, NONE},
        '{OP_TEST,   32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 32'h0, 1'b0}},
        '{OP_SEEK,   32'h0000_0006, 32'h0000_0000, 1'b1,
          '{1'b1, 32'h0000_000A, 32'h0001_0000, 1'b0}},
        '{OP_SEEK,   32'h0000_0007, 32'h0000_0000, 1'b0, ANY},
        '{OP_TEST,   32'h0000_000A, 32'h0000_0000, 1'b0, ANY},
        '{OP_SEEK,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0}},
        '{OP_TEST,   32'h0000_0005, 32'h0000_0000, 1'b0, ANY},
        '{OP_APPEND, 32'h0000_0003, 32'hDEAD_BEEF, 1'b1, NONE},
        '{OP_SEEK,   32'h0000_0004, 32'h0000_0000, 1'b0, ANY},
        '{OP_TEST,   32'h0000_0003, 32'h0000_0000, 1'b0, ANY},
        '{OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NONE},
        '{OP_APPEND, 32'h0000_0064, 32'h0000_0007, 1'b1, NONE},
        '{OP_SEEK,   32'h0000_0065, 32'h0000_0000, 1'b1, NONE},
        '{OP_SEEK,   32'h0000_00C8, 32'h0000_0000, 1'b0, ANY},
        '{OP_TEST,   32'h0000_0064, 32'h0000_0000, 1'b0, ANY},
        '{OP_SEEK,   32'h0000_0032, 32'h0000_0000, 1'b0, ANY},
        '{OP_TEST,   32'h0000_0065, 32'h0000_0000, 1'b0, ANY},
        '{OP_SEEK,   32'h0000_0000, 32'h0000_0000, 1'b0, ANY}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd = '0;
    logic [ID_W-1:0]    doc_id = '0;
    logic [SCORE_W-1:0] score_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               hit;
    logic [ID_W-1:0]    found_id;
    logic [SCORE_W-1:0] score_out;
    logic               list_full;

    sorted_id_list_cursor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .doc_id    (doc_id),
        .score_in  (score_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .found_id  (found_id),
        .score_out (score_out),
        .list_full (list_full)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [ID_W-1:0]    mdl_ids    [LIST_DEPTH];
    logic [SCORE_W-1:0] mdl_scores [LIST_DEPTH];
    int unsigned        mdl_count = 0;
    int unsigned        mdl_cursor = 0;
    bit                 win_valid = 1'b0;
    bit                 win_end = 1'b0;
    logic [ID_W-1:0]    win_low = '0;
    logic [ID_W-1:0]    win_high = '0;

    lookup_t pending_lookups [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int words_sent = 0;
    int random_words = 0;
    int full_refusals = 0;
    int quiet_cycles = 0;

    function automatic void forget_window();
        win_valid  = 1'b0;
        win_end    = 1'b0;
        win_low    = '0;
        win_high   = '0;
        mdl_cursor = 0;
    endfunction

    function automatic lookup_t predict_cursor(sidc_op_t op, logic [ID_W-1:0] id,
                                               logic [SCORE_W-1:0] sc);
        lookup_t     r;
        int unsigned i;
        bit          done;
        r    = '0;
        i    = 0;
        done = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                mdl_count = 0;
                forget_window();
            end
            OP_APPEND:
            begin
                if (mdl_count >= LIST_DEPTH)
                    r.full = 1'b1;
                else
                begin
                    mdl_ids[mdl_count]    = id;
                    mdl_scores[mdl_count] = sc;
                    mdl_count++;
                    forget_window();
                end
            end
            OP_TEST:
            begin
                if (win_valid && id >= win_low)
                begin
                    if (!win_end && id == win_high)
                    begin
                        r.hit   = 1'b1;
                        r.found = id;
                        r.score = (mdl_cursor < mdl_count) ? mdl_scores[mdl_cursor] : '0;
                        done    = 1'b1;
                    end
                    else if (win_end || id < win_high)
                        done = 1'b1;
                    else
                        i = mdl_cursor + 1;
                end
                // scan stops at the first stored id above the one tested
                while (!done && i < mdl_count && mdl_ids[i] <= id)
                begin
                    if (mdl_ids[i] == id)
                    begin
                        win_low    = id;
                        win_high   = id;
                        mdl_cursor = i;
                        win_valid  = 1'b1;
                        win_end    = 1'b0;
                        r.hit      = 1'b1;
                        r.found    = id;
                        r.score    = mdl_scores[i];
                        done       = 1'b1;
                    end
                    else
                        i++;
                end
            end
            default:
            begin
                if (win_valid && id >= win_low)
                begin
                    if (win_end)
                        done = 1'b1;
                    else if (id <= win_high)
                    begin
                        r.hit   = 1'b1;
                        r.found = win_high;
                        r.score = (mdl_cursor < mdl_count) ? mdl_scores[mdl_cursor] : '0;
                        done    = 1'b1;
                    end
                    else
                        i = mdl_cursor + 1;
                end
                if (!done)
                begin
                    win_low   = id;
                    win_valid = 1'b1;
                    while (!done && i < mdl_count)
                    begin
                        if (mdl_ids[i] >= id)
                        begin
                            win_high   = mdl_ids[i];
                            mdl_cursor = i;
                            win_end    = 1'b0;
                            r.hit      = 1'b1;
                            r.found    = mdl_ids[i];
                            r.score    = mdl_scores[i];
                            done       = 1'b1;
                        end
                        else
                            i++;
                    end
                    if (!done)
                        win_end = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // entered and left at a falling edge; in_valid gets one assignment per edge
    task automatic send_word(sidc_op_t op, logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc,
                             bit typed, lookup_t typed_res);
        lookup_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        doc_id   <= id;
        score_in <= sc;
        do
            @(posedge clk);
        while (!in_ready);
        r = predict_cursor(op, id, sc);
        if (r.full)
            full_refusals++;
        pending_lookups.push_back(typed ? typed_res : r);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] clamp_id(logic [ID_W:0] v);
        return v[ID_W] ? {ID_W{1'b1}} : v[ID_W-1:0];
    endfunction

    // one list build followed by a run of queries
    task automatic run_episode();
        int              n;
        int              q;
        int              r;
        int              k;
        logic [ID_W:0]   nxt;
        logic [ID_W:0]   walk;
        logic [ID_W-1:0] qid;
        sidc_op_t        op;
        if (mdl_count > 900 || $urandom_range(99) < 80)
            send_word(OP_CLEAR, $urandom, $urandom, 1'b0, ANY);
        case ($urandom_range(3))
            0: nxt = '0;
            1: nxt = {1'b0, 32'($urandom_range(50))};
            2: nxt = {1'b0, $urandom};
            default: nxt = {1'b0, 32'hFFFF_FFFF - 32'($urandom_range(100))};
        endcase
        walk = nxt;
        n = $urandom_range(0, 24);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(19) == 0)
                send_word(OP_APPEND, $urandom, $urandom, 1'b0, ANY);
            else
                send_word(OP_APPEND, clamp_id(nxt), $urandom, 1'b0, ANY);
            // a zero gap gives a duplicate id
            nxt = nxt + $urandom_range(0, 4);
        end
        q = $urandom_range(1, 20);
        for (k = 0; k < q; k++)
        begin
            r  = $urandom_range(99);
            op = $urandom_range(1) ? OP_TEST : OP_SEEK;
            if (r < 55)
            begin
                walk = walk + $urandom_range(0, 6);
                qid  = clamp_id(walk);
            end
            else if (r < 80 && mdl_count > 0)
                qid = mdl_ids[$urandom_range(0, mdl_count - 1)];
            else if (r < 93)
                qid = $urandom;
            else
            begin
                qid = $urandom;
                op  = sidc_op_t'($urandom_range(3));
            end
            send_word(op, qid, $urandom, 1'b0, ANY);
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result with nothing expected:",
                              " hit=%0b id=%08h score=%08h full=%0b"},
                             $realtime, hit, found_id, score_out, list_full);
            end
            else
            begin
                e = pending_lookups.pop_front();
                if (hit !== e.hit || found_id !== e.found || score_out !== e.score
                    || list_full !== e.full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch exp hit=%0b id=%08h score=%08h full=%0b",
                                  " got hit=%0b id=%08h score=%08h full=%0b"},
                                 $realtime, e.hit, e.found, e.score, e.full,
                                 hit, found_id, score_out, list_full);
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d results still owed", pending_lookups.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int ep;
        int before_ep;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send_word(DIR_TABLE[k].op, DIR_TABLE[k].id, DIR_TABLE[k].sc,
                      DIR_TABLE[k].typed, DIR_TABLE[k].res);

        ep = 0;
        while (random_words < RANDOM_WORDS)
        begin
            // idling profile rotates per episode, including stretches with none
            case (ep % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            before_ep = words_sent;
            run_episode();
            random_words += words_sent - before_ep;
            ep++;
        end
        in_valid <= 1'b0;

        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d directed and %0d random words in %0d episodes",
                 DIR_ROWS, words_sent - DIR_ROWS, ep);
        $display("checked %0d results, %0d refused appends, %0d mismatches",
                 results_seen, full_refusals, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
